// ===== sv/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

	typedef logic [0:7][31:0] hash_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} md_state_t;

	typedef enum logic [1:0] {
		PK_MARK,
		PK_ZERO,
		PK_LEN,
		PK_DONE
	} pad_kind_t;

	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       start;
		logic       init;
	} core_ctrl_t;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LAST_SLOT  = 6'd63;
	localparam logic [5:0] LEN_SLOT   = 6'd56;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [1:0] LAST_CHUNK = 2'd3;

	localparam hash_t HASH_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ===== sv/sha256_core.sv =====
`timescale 1ns / 1ps

module sha256_core import sha256_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctrl_t ctrl,
	output logic       busy,
	output hash_t      hash
);

	// block buffer doubles as the schedule window; word 0 sits at the top
	logic [511:0] win_q;
	hash_t        chain_q;
	hash_t        work_q;
	logic [31:0]  w_q;
	logic [5:0]   round_q;
	logic         phase_q;
	logic         run_q;
	logic         fin_q;

	logic [31:0] win_w0, win_w1, win_w9, win_w14;
	logic [31:0] next_w;
	logic [31:0] t1, t2;

	assign win_w0  = win_q[511:480];
	assign win_w1  = win_q[479:448];
	assign win_w9  = win_q[223:192];
	assign win_w14 = win_q[63:32];

	always_comb begin
		if (round_q < 6'd16) begin
			next_w = win_w0;
		end else begin
			next_w = win_w0 + small_sigma0(win_w1) + win_w9 + small_sigma1(win_w14);
		end
	end

	always_comb begin
		t1 = work_q[7] + big_sigma1(work_q[4])
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ ROUND_K[round_q] + w_q;
		t2 = big_sigma0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
	end

	// byte intake and schedule shift share the window register
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			win_q <= {win_q[503:0], ctrl.data};
		end else if (run_q && !phase_q) begin
			win_q <= {win_q[479:0], next_w};
			w_q   <= next_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= HASH_IV;
			work_q  <= '0;
			round_q <= '0;
			phase_q <= 1'b0;
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			if (ctrl.start) begin
				work_q  <= chain_q;
				round_q <= '0;
				phase_q <= 1'b0;
				run_q   <= 1'b1;
			end else if (run_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					work_q  <= {t1 + t2, work_q[0], work_q[1], work_q[2],
						work_q[3] + t1, work_q[4], work_q[5], work_q[6]};
					round_q <= round_q + 6'd1;
					if (round_q == LAST_ROUND) begin
						run_q <= 1'b0;
						fin_q <= 1'b1;
					end
				end
			end
			if (fin_q) begin
				fin_q <= 1'b0;
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end else if (ctrl.init) begin
				chain_q <= HASH_IV;
			end
		end
	end

	assign busy = run_q | fin_q;
	assign hash = chain_q;

endmodule

// ===== sv/sha256_message_digest.sv =====
`timescale 1ns / 1ps

// SHA-256 digest of a byte stream. Send one message byte per msg beat with
// byte_present high; set end_of_message on the final beat (byte_present low
// there closes the message without a byte, which is also how an empty
// message is sent). Bytes are taken at one per cycle until a 64-byte block
// is full; the block then stalls while a single shared round unit runs the
// 64 rounds, each a schedule word step then a round update step, then folds
// the result into the chaining words and hands the block back; the input
// stalls through all of this after each 64-byte block. On the closing beat
// the padding (0x80, zeros, 64-bit bit length) is fed through the same byte
// path, compressing one or two final blocks, and the digest then leaves as
// four 64-bit digest beats, hash words 0 and 1 first, chunk_last on the
// fourth. After the fourth beat the block is back in its reset state.

module sha256_message_digest import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [63:0] digest_chunk,
	output logic        chunk_last
);

	md_state_t  state_q, state_d;
	pad_kind_t  kind_q, kind_d;
	logic [63:0] len_q, len_d;
	logic [5:0]  fill_q, fill_d;
	logic [1:0]  chunk_q, chunk_d;
	logic        eom_q, eom_d;

	core_ctrl_t ctrl;
	logic       core_busy;
	hash_t      hash;
	logic       push;
	logic [7:0] push_byte;

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.busy   (core_busy),
		.hash   (hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= PK_MARK;
			len_q   <= '0;
			fill_q  <= '0;
			chunk_q <= '0;
			eom_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
			chunk_q <= chunk_d;
			eom_q   <= eom_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		len_d        = len_q;
		fill_d       = fill_q;
		chunk_d      = chunk_q;
		eom_d        = eom_q;
		ctrl         = '0;
		push         = 1'b0;
		push_byte    = 8'h00;
		msg_stall    = 1'b1;
		digest_valid = 1'b0;

		case (state_q)
			ST_IDLE: begin
				msg_stall = 1'b0;
				if (msg_valid) begin
					kind_d = PK_MARK;
					eom_d  = end_of_message;
					if (byte_present) begin
						push      = 1'b1;
						push_byte = msg_byte;
						len_d     = len_q + 64'd8;
					end
					// a full block wins; the pad starts once it is compressed
					if (end_of_message && !(byte_present && fill_q == LAST_SLOT)) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				case (kind_q)
					PK_MARK: begin
						push      = 1'b1;
						push_byte = PAD_MARK;
						kind_d    = PK_ZERO;
					end
					PK_ZERO: begin
						if (fill_q == LEN_SLOT) begin
							kind_d = PK_LEN;
						end else begin
							push = 1'b1;
						end
					end
					PK_LEN: begin
						// shift the length out most significant byte first
						push      = 1'b1;
						push_byte = len_q[63:56];
						len_d     = {len_q[55:0], 8'h00};
						if (fill_q == LAST_SLOT) begin
							kind_d = PK_DONE;
						end
					end
					default: begin
						state_d = ST_OUT;
					end
				endcase
			end
			ST_COMP: begin
				if (!core_busy) begin
					if (!eom_q) begin
						state_d = ST_IDLE;
					end else if (kind_q == PK_DONE) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_OUT: begin
				digest_valid = 1'b1;
				if (!digest_stall) begin
					chunk_d = chunk_q + 2'd1;
					if (chunk_q == LAST_CHUNK) begin
						// drop back to the reset state for the next message
						ctrl.init = 1'b1;
						len_d     = '0;
						fill_d    = '0;
						eom_d     = 1'b0;
						kind_d    = PK_MARK;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// every byte, message or pad, advances the fill slot; the last slot
		// hands the block to the round unit
		if (push) begin
			ctrl.load = 1'b1;
			ctrl.data = push_byte;
			fill_d    = fill_q + 6'd1;
			if (fill_q == LAST_SLOT) begin
				ctrl.start = 1'b1;
				state_d    = ST_COMP;
			end
		end
	end

	always_comb begin
		case (chunk_q)
			2'd0:    digest_chunk = {hash[0], hash[1]};
			2'd1:    digest_chunk = {hash[2], hash[3]};
			2'd2:    digest_chunk = {hash[4], hash[5]};
			default: digest_chunk = {hash[6], hash[7]};
		endcase
	end

	assign chunk_last = (chunk_q == LAST_CHUNK);

endmodule

// ===== sv/sha256_checker.sv =====
`timescale 1ns / 1ps

module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_stall,
	input logic        end_of_message,
	input logic        digest_valid,
	input logic        digest_stall,
	input logic [63:0] digest_chunk,
	input logic        chunk_last
);

	// no message beat is taken while the digest is going out
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> msg_stall)
		else $error("message beat open during digest output");

	// the closing beat always stalls the next cycle, for padding or for compressing a full block
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_stall && end_of_message) |=> msg_stall)
		else $error("no stall after closing beat");

	// the last digest beat returns the block to idle
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && chunk_last) |=> (!digest_valid && !msg_stall))
		else $error("block not idle after last digest beat");

	// output ends only on an accepted last beat
	a_fall_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(digest_valid) |-> $past(chunk_last && !digest_stall))
		else $error("digest output ended early");

	// a stalled digest beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && digest_stall) |=>
			(digest_valid && $stable(digest_chunk) && $stable(chunk_last)))
		else $error("stalled digest beat changed");

endmodule

bind sha256_message_digest sha256_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.msg_valid      (msg_valid),
	.msg_stall      (msg_stall),
	.end_of_message (end_of_message),
	.digest_valid   (digest_valid),
	.digest_stall   (digest_stall),
	.digest_chunk   (digest_chunk),
	.chunk_last     (chunk_last)
);
